/* hdl/bbsr_pkg.sv */
`timescale 1ns / 1ps

package bbsr_pkg;

   localparam int DEF_MAX_DEPTH = 32;
   localparam int RESULT_LIMIT  = 32;

   localparam int OP_W     = 3;
   localparam int VAL_W    = 8;
   localparam int K_W      = 6;
   localparam int CAP_W    = 6;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CAP_W-1:0] RESET_CAPACITY = 6'd32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_PEEK     = 3'd2,
      OP_DUP      = 3'd3,
      OP_ROT_UP   = 3'd4,
      OP_ROT_DOWN = 3'd5,
      OP_PRINT    = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_BAD_DEPTH = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TOP,
      ST_DUP,
      ST_ROT_SAVE,
      ST_ROT_STEP,
      ST_ROT_MOVE,
      ST_PR_EMIT,
      ST_PR_RD
   } state_type;

   // Read address source.
   typedef enum logic [1:0] {
      RD_START,
      RD_PTR,
      RD_NEIGH
   } rd_sel_type;

   // Write address and data source.
   typedef enum logic [1:0] {
      WR_PUSH,
      WR_DUP,
      WR_MOVE,
      WR_TMP
   } wr_sel_type;

   // What a result carries.
   typedef enum logic [1:0] {
      EMIT_PLAIN,
      EMIT_DATA,
      EMIT_PRINT
   } emit_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       ptr_load;
      logic       ptr_step;
      logic       tmp_load;
      logic       emit;
      emit_type   emit_kind;
      status_type emit_status;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   k_bad;
      logic   at_end;
      logic   left_one;
      logic   out_free;
   } ctrl_sts_type;

endpackage

/* hdl/bbsr_ctrl.sv */
`timescale 1ns / 1ps

module bbsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bbsr_pkg::ctrl_sts_type sts,
   output bbsr_pkg::ctrl_cmd_type cmd
);

   bbsr_pkg::state_type state_ff;
   bbsr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbsr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bbsr_pkg::ST_EXEC;
         end
         bbsr_pkg::ST_EXEC: begin
            unique case (sts.op)
               bbsr_pkg::OP_POP, bbsr_pkg::OP_PEEK: begin
                  if (!sts.empty) state_in = bbsr_pkg::ST_TOP;
                  else if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
               end
               bbsr_pkg::OP_DUP: begin
                  if (!sts.full && !sts.empty) state_in = bbsr_pkg::ST_DUP;
                  else if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
               end
               bbsr_pkg::OP_ROT_UP, bbsr_pkg::OP_ROT_DOWN: begin
                  if (!sts.k_bad) state_in = bbsr_pkg::ST_ROT_SAVE;
                  else if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
               end
               bbsr_pkg::OP_PRINT: begin
                  if (!sts.empty) state_in = bbsr_pkg::ST_PR_EMIT;
                  else if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
               end
               default: begin
                  if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
               end
            endcase
         end
         bbsr_pkg::ST_TOP, bbsr_pkg::ST_DUP: begin
            if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
         end
         bbsr_pkg::ST_ROT_SAVE: state_in = bbsr_pkg::ST_ROT_STEP;
         bbsr_pkg::ST_ROT_STEP: begin
            if (!sts.at_end) state_in = bbsr_pkg::ST_ROT_MOVE;
            else if (sts.out_free) state_in = bbsr_pkg::ST_IDLE;
         end
         bbsr_pkg::ST_ROT_MOVE: state_in = bbsr_pkg::ST_ROT_STEP;
         bbsr_pkg::ST_PR_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.left_one ? bbsr_pkg::ST_IDLE : bbsr_pkg::ST_PR_RD;
            end
         end
         bbsr_pkg::ST_PR_RD: state_in = bbsr_pkg::ST_PR_EMIT;
         default: state_in = bbsr_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = bbsr_pkg::ctrl_cmd_type'('0);
      req_tready = 1'b0;
      unique case (state_ff)
         bbsr_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.latch_req = req_tvalid;
         end
         bbsr_pkg::ST_EXEC: begin
            unique case (sts.op)
               bbsr_pkg::OP_PUSH: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     if (sts.full) begin
                        cmd.emit_status = bbsr_pkg::STS_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = bbsr_pkg::WR_PUSH;
                        cmd.cnt_inc = 1'b1;
                     end
                  end
               end
               bbsr_pkg::OP_POP, bbsr_pkg::OP_PEEK: begin
                  if (!sts.empty) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bbsr_pkg::RD_START;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = bbsr_pkg::STS_EMPTY;
                  end
               end
               bbsr_pkg::OP_DUP: begin
                  if (!sts.full && !sts.empty) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bbsr_pkg::RD_START;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sts.full ? bbsr_pkg::STS_FULL : bbsr_pkg::STS_EMPTY;
                  end
               end
               bbsr_pkg::OP_ROT_UP, bbsr_pkg::OP_ROT_DOWN: begin
                  if (!sts.k_bad) begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = bbsr_pkg::RD_START;
                     cmd.ptr_load = 1'b1;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = bbsr_pkg::STS_BAD_DEPTH;
                  end
               end
               bbsr_pkg::OP_PRINT: begin
                  if (!sts.empty) begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = bbsr_pkg::RD_START;
                     cmd.ptr_load = 1'b1;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = bbsr_pkg::STS_EMPTY;
                  end
               end
               default: begin
                  cmd.emit = sts.out_free;
               end
            endcase
         end
         bbsr_pkg::ST_TOP: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = bbsr_pkg::EMIT_DATA;
               cmd.cnt_dec   = (sts.op == bbsr_pkg::OP_POP);
            end
         end
         bbsr_pkg::ST_DUP: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = bbsr_pkg::WR_DUP;
               cmd.cnt_inc = 1'b1;
            end
         end
         bbsr_pkg::ST_ROT_SAVE: begin
            cmd.tmp_load = 1'b1;
         end
         bbsr_pkg::ST_ROT_STEP: begin
            if (!sts.at_end) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bbsr_pkg::RD_NEIGH;
            end else if (sts.out_free) begin
               // The saved byte lands in its final slot with the result.
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = bbsr_pkg::WR_TMP;
               cmd.emit   = 1'b1;
            end
         end
         bbsr_pkg::ST_ROT_MOVE: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = bbsr_pkg::WR_MOVE;
            cmd.ptr_step = 1'b1;
         end
         bbsr_pkg::ST_PR_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = bbsr_pkg::EMIT_PRINT;
               cmd.ptr_step  = 1'b1;
            end
         end
         bbsr_pkg::ST_PR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bbsr_pkg::RD_PTR;
         end
         default: begin
            cmd = bbsr_pkg::ctrl_cmd_type'('0);
         end
      endcase
   end

endmodule

/* hdl/bbsr_dp.sv */
`timescale 1ns / 1ps

module bbsr_dp #(
   parameter int MAX_DEPTH = bbsr_pkg::DEF_MAX_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bbsr_pkg::OP_W-1:0]       req_op,
   input  logic [bbsr_pkg::VAL_W-1:0]      req_push_value,
   input  logic [bbsr_pkg::K_W-1:0]        req_rotate_depth,
   input  logic                            csr_wr_en,
   input  logic [bbsr_pkg::CAP_W-1:0]      csr_wr_data,
   input  logic                            rsp_tready,
   output logic                            rsp_valid,
   output logic [bbsr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bbsr_pkg::VAL_W-1:0]      rsp_data_out,
   output logic                            rsp_data_valid,
   output logic                            rsp_last,
   input  bbsr_pkg::ctrl_cmd_type          cmd,
   output bbsr_pkg::ctrl_sts_type          sts
);

   localparam int AW    = $clog2(MAX_DEPTH);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int KW    = (CNT_W > bbsr_pkg::K_W) ? CNT_W : bbsr_pkg::K_W;
   localparam int CW    = (CNT_W > bbsr_pkg::CAP_W) ? CNT_W : bbsr_pkg::CAP_W;

   logic [bbsr_pkg::VAL_W-1:0] mem [MAX_DEPTH];

   logic [bbsr_pkg::OP_W-1:0]     op_ff;
   logic [bbsr_pkg::VAL_W-1:0]    val_ff;
   logic [bbsr_pkg::K_W-1:0]      k_ff;
   logic [bbsr_pkg::CAP_W-1:0]    cap_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [AW-1:0]                 ptr_ff;
   logic [CNT_W-1:0]              left_ff;
   logic [bbsr_pkg::VAL_W-1:0]    tmp_ff;
   logic [bbsr_pkg::VAL_W-1:0]    rd_ff;
   logic                          rsp_valid_ff;
   logic [bbsr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bbsr_pkg::VAL_W-1:0]    rsp_data_ff;
   logic                          rsp_dv_ff;
   logic                          rsp_last_ff;

   logic                       is_down;
   logic [AW-1:0]              top_addr;
   logic [AW-1:0]              idx_addr;
   logic [AW-1:0]              start_addr;
   logic [AW-1:0]              end_addr;
   logic [AW-1:0]              neigh_addr;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic [bbsr_pkg::VAL_W-1:0] wr_data;
   logic [CNT_W-1:0]           print_len;

   assign is_down    = (bbsr_pkg::op_type'(op_ff) == bbsr_pkg::OP_ROT_DOWN);
   assign top_addr   = AW'(count_ff - CNT_W'(1));
   assign idx_addr   = AW'(KW'(count_ff) - KW'(k_ff));
   // Up-rotate walks from the top down to depth k; down-rotate the other way.
   assign start_addr = is_down ? idx_addr : top_addr;
   assign end_addr   = is_down ? top_addr : idx_addr;
   assign neigh_addr = is_down ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
   assign print_len  = (32'(count_ff) > bbsr_pkg::RESULT_LIMIT) ?
                       CNT_W'(bbsr_pkg::RESULT_LIMIT) : count_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         bbsr_pkg::RD_START: rd_addr = start_addr;
         bbsr_pkg::RD_PTR:   rd_addr = ptr_ff;
         bbsr_pkg::RD_NEIGH: rd_addr = neigh_addr;
         default:            rd_addr = start_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         bbsr_pkg::WR_PUSH: begin
            wr_addr = AW'(count_ff);
            wr_data = val_ff;
         end
         bbsr_pkg::WR_DUP: begin
            wr_addr = AW'(count_ff);
            wr_data = rd_ff;
         end
         bbsr_pkg::WR_MOVE: begin
            wr_addr = ptr_ff;
            wr_data = rd_ff;
         end
         default: begin
            wr_addr = ptr_ff;
            wr_data = tmp_ff;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff  <= req_op;
         val_ff <= req_push_value;
         k_ff   <= req_rotate_depth;
      end
      if (cmd.tmp_load) begin
         tmp_ff <= rd_ff;
      end
      if (cmd.ptr_load) begin
         ptr_ff  <= start_addr;
         left_ff <= print_len;
      end else if (cmd.ptr_step) begin
         ptr_ff  <= neigh_addr;
         left_ff <= left_ff - CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_data_ff   <= (cmd.emit_kind == bbsr_pkg::EMIT_PLAIN) ? '0 : rd_ff;
         rsp_dv_ff     <= (cmd.emit_kind != bbsr_pkg::EMIT_PLAIN);
         rsp_last_ff   <= (cmd.emit_kind != bbsr_pkg::EMIT_PRINT) ||
                          (left_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= bbsr_pkg::RESET_CAPACITY;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.op       = bbsr_pkg::op_type'(op_ff);
   // A capacity above the depth acts as the depth itself.
   assign sts.full     = (CW'(count_ff) >= CW'(cap_ff)) || (count_ff == CNT_W'(MAX_DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.k_bad    = (k_ff == '0) || (KW'(k_ff) > KW'(count_ff));
   assign sts.at_end   = (ptr_ff == end_addr);
   assign sts.left_one = (left_ff == CNT_W'(1));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_data_valid = rsp_dv_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* hdl/bounded_byte_stack_with_rotate_unit.sv */
`timescale 1ns / 1ps

// Byte stack of up to MAX_DEPTH entries with push, pop, peek, duplicate, up/down
// rotate to depth k and print, one request at a time. Entries sit in a single-port
// memory with a registered read, and the sequencer walks it one access per cycle,
// pausing while a result waits on a stalled result side. Push, a refused or
// ignored command and opcode seven read no entry; pop, peek and duplicate read
// the top entry; a rotate to depth k moves k-1 entries, each a read then a write;
// print of n results does one memory read per entry. A new request is taken once
// the last result of the previous one sits in the output register, so a waiting
// result does not hold off the next request. The stack is empty after reset and
// the capacity register reads 32; entries never written hold no defined value.
module bounded_byte_stack_with_rotate_unit #(
   parameter int MAX_DEPTH = bbsr_pkg::DEF_MAX_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bbsr_pkg::REQ_TDATA_W-1:0]  req_tdata,  // push_value, rotate_depth, zero pad
   input  logic [bbsr_pkg::OP_W-1:0]         req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bbsr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // status, data_out, zero pad
   output logic                              rsp_tuser,  // data_valid
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [bbsr_pkg::CAP_W-1:0]        csr_wr_data
);

   localparam int PAD_W = bbsr_pkg::RSP_TDATA_W - bbsr_pkg::STATUS_W - bbsr_pkg::VAL_W;

   bbsr_pkg::ctrl_cmd_type cmd;
   bbsr_pkg::ctrl_sts_type sts;

   logic [bbsr_pkg::STATUS_W-1:0] rsp_status;
   logic [bbsr_pkg::VAL_W-1:0]    rsp_data_out;

   bbsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbsr_dp #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_tuser),
      .req_push_value   (req_tdata[bbsr_pkg::VAL_W-1:0]),
      .req_rotate_depth (req_tdata[bbsr_pkg::VAL_W +: bbsr_pkg::K_W]),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_data_valid   (rsp_tuser),
      .rsp_last         (rsp_tlast),
      .cmd              (cmd),
      .sts              (sts)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_data_out, rsp_status};

endmodule

/* hdl/bbsr_checker.sv */
`timescale 1ns / 1ps

module bbsr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bbsr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only one request is in flight.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // A result that carries a byte always reports status ok.
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == bbsr_pkg::STS_OK)
      else $error("data result with non-ok status");

   // A result without a byte carries a zero data field.
   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[9:2] == 8'd0)
      else $error("non-data result carries data");

   // Only a print result can be non-final, and it always carries a byte.
   a_nonlast_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("non-final result without data");

endmodule

bind bounded_byte_stack_with_rotate_unit bbsr_checker u_bbsr_checker (.*);
